>>> hdl/csed_pkg.sv
// Shared types, codes and the evaluation program of the cubic spline evaluator.
// Depends on nothing; csed_dp, csed_ctrl, the top level and the testbench import it.
package csed_pkg;

    localparam int DATA_W = 32;
    localparam int WIDE_W = 64;
    localparam int PC_W   = 6;
    localparam logic [PC_W-1:0] PROG_LAST = PC_W'(44);

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_DIV6,
        OP_CLAMP
    } alu_op_t;

    typedef enum logic [3:0] {
        R_X,
        R_XLO,
        R_XHI,
        R_YLO,
        R_YHI,
        R_CLO,
        R_CHI,
        R_H,
        R_A,
        R_B,
        R_T,
        R_U,
        R_V,
        R_W,
        R_ONE
    } reg_sel_t;

    typedef struct packed {
        alu_op_t  op;
        reg_sel_t dst;
        reg_sel_t sa;
        reg_sel_t sb;
    } insn_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_LOAD_LO,
        ST_LOAD_HI,
        ST_LOAD_END,
        ST_ISSUE,
        ST_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic  wr_en;
        logic  load_x;
        logic  load_lo;
        logic  load_hi;
        logic  start;
        logic  clear_sat;
        logic  load_out;
        logic  bad;
        insn_t insn;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic h_zero;
        logic gt;
    } status_t;

    function automatic insn_t mk(alu_op_t op, reg_sel_t d, reg_sel_t a, reg_sel_t b);
        insn_t r;
        r.op  = op;
        r.dst = d;
        r.sa  = a;
        r.sb  = b;
        return r;
    endfunction

    // Evaluation program; the first step computes the knot spacing.
    function automatic insn_t prog(logic [PC_W-1:0] pc);
        insn_t r;
        case (pc)
            6'd0:    r = mk(OP_SUB, R_H, R_XHI, R_XLO);
            6'd1:    r = mk(OP_SUB, R_T, R_XHI, R_X);
            6'd2:    r = mk(OP_DIV, R_A, R_T, R_H);
            6'd3:    r = mk(OP_SUB, R_T, R_X, R_XLO);
            6'd4:    r = mk(OP_DIV, R_B, R_T, R_H);
            6'd5:    r = mk(OP_MUL, R_T, R_A, R_A);
            6'd6:    r = mk(OP_MUL, R_T, R_T, R_A);
            6'd7:    r = mk(OP_SUB, R_T, R_T, R_A);
            6'd8:    r = mk(OP_MUL, R_T, R_T, R_CLO);
            6'd9:    r = mk(OP_MUL, R_U, R_B, R_B);
            6'd10:   r = mk(OP_MUL, R_U, R_U, R_B);
            6'd11:   r = mk(OP_SUB, R_U, R_U, R_B);
            6'd12:   r = mk(OP_MUL, R_U, R_U, R_CHI);
            6'd13:   r = mk(OP_ADD, R_T, R_T, R_U);
            6'd14:   r = mk(OP_MUL, R_U, R_H, R_H);
            6'd15:   r = mk(OP_MUL, R_T, R_T, R_U);
            6'd16:   r = mk(OP_DIV6, R_T, R_T, R_T);
            6'd17:   r = mk(OP_MUL, R_U, R_A, R_YLO);
            6'd18:   r = mk(OP_MUL, R_V, R_B, R_YHI);
            6'd19:   r = mk(OP_ADD, R_U, R_U, R_V);
            6'd20:   r = mk(OP_ADD, R_V, R_U, R_T);
            6'd21:   r = mk(OP_CLAMP, R_V, R_V, R_V);
            6'd22:   r = mk(OP_MUL, R_T, R_A, R_A);
            6'd23:   r = mk(OP_ADD, R_W, R_T, R_T);
            6'd24:   r = mk(OP_ADD, R_T, R_W, R_T);
            6'd25:   r = mk(OP_SUB, R_T, R_T, R_ONE);
            6'd26:   r = mk(OP_MUL, R_T, R_T, R_H);
            6'd27:   r = mk(OP_MUL, R_T, R_T, R_CLO);
            6'd28:   r = mk(OP_DIV6, R_T, R_T, R_T);
            6'd29:   r = mk(OP_MUL, R_U, R_B, R_B);
            6'd30:   r = mk(OP_ADD, R_W, R_U, R_U);
            6'd31:   r = mk(OP_ADD, R_U, R_W, R_U);
            6'd32:   r = mk(OP_SUB, R_U, R_U, R_ONE);
            6'd33:   r = mk(OP_MUL, R_U, R_U, R_H);
            6'd34:   r = mk(OP_MUL, R_U, R_U, R_CHI);
            6'd35:   r = mk(OP_DIV6, R_U, R_U, R_U);
            6'd36:   r = mk(OP_SUB, R_W, R_YHI, R_YLO);
            6'd37:   r = mk(OP_DIV, R_W, R_W, R_H);
            6'd38:   r = mk(OP_SUB, R_W, R_W, R_T);
            6'd39:   r = mk(OP_ADD, R_W, R_W, R_U);
            6'd40:   r = mk(OP_CLAMP, R_W, R_W, R_W);
            6'd41:   r = mk(OP_MUL, R_T, R_A, R_CLO);
            6'd42:   r = mk(OP_MUL, R_U, R_B, R_CHI);
            6'd43:   r = mk(OP_ADD, R_T, R_T, R_U);
            6'd44:   r = mk(OP_CLAMP, R_T, R_T, R_T);
            default: r = mk(OP_ADD, R_T, R_T, R_T);
        endcase
        return r;
    endfunction

endpackage

>>> hdl/csed_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/csed_dp.sv
// Datapath: knot tables, working registers, shared multiply/divide unit, result register.
// Depends on csed_pkg and csed_ram.
module csed_dp
    import csed_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cmd_t                          cmd,
    input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    output status_t                       status,
    input  logic [9:0]                    knot_index,
    input  logic [DATA_W-1:0]             knot_abscissa,
    input  logic [DATA_W-1:0]             knot_ordinate,
    input  logic [DATA_W-1:0]             knot_curvature,
    input  logic [DATA_W-1:0]             query_x,
    output logic [DATA_W-1:0]             interp_value,
    output logic [DATA_W-1:0]             first_deriv,
    output logic [DATA_W-1:0]             second_deriv,
    output logic                          bad_spacing,
    output logic                          saturated
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam logic [WIDE_W-1:0] ONE_Q = WIDE_W'(1) << FRAC_BITS;
    localparam logic [WIDE_W-1:0] S_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic [WIDE_W-1:0] S_MIN = {1'b1, {(WIDE_W-1){1'b0}}};
    // A divide by six halves the operand, then multiplies by the reciprocal of three
    // scaled by 2^65; the quotient is the product shifted right by 65.
    localparam logic [WIDE_W-1:0] DIV3_MAGIC = 64'hAAAA_AAAA_AAAA_AAAB;

    // Result with saturation flag in the top bit.
    function automatic logic [WIDE_W:0] from_mag(logic [WIDE_W-1:0] m, logic neg, logic over);
        logic [WIDE_W:0] r;
        if (neg) begin
            if (over || (m > S_MIN)) r = {1'b1, S_MIN};
            else r = {1'b0, WIDE_W'(-m)};
        end else begin
            if (over || m[WIDE_W-1]) r = {1'b1, S_MAX};
            else r = {1'b0, m};
        end
        return r;
    endfunction

    function automatic logic [WIDE_W-1:0] mag(logic [WIDE_W-1:0] v);
        return v[WIDE_W-1] ? WIDE_W'(-v) : v;
    endfunction

    function automatic logic [WIDE_W:0] sat_add(logic [WIDE_W-1:0] a, logic [WIDE_W-1:0] b);
        logic [WIDE_W-1:0] s;
        logic [WIDE_W:0]   r;
        s = a + b;
        if (a[WIDE_W-1] == b[WIDE_W-1] && s[WIDE_W-1] != a[WIDE_W-1])
            r = {1'b1, a[WIDE_W-1] ? S_MIN : S_MAX};
        else r = {1'b0, s};
        return r;
    endfunction

    function automatic logic [WIDE_W:0] sat_sub(logic [WIDE_W-1:0] a, logic [WIDE_W-1:0] b);
        logic [WIDE_W-1:0] s;
        logic [WIDE_W:0]   r;
        s = a - b;
        if (a[WIDE_W-1] != b[WIDE_W-1] && s[WIDE_W-1] != a[WIDE_W-1])
            r = {1'b1, a[WIDE_W-1] ? S_MIN : S_MAX};
        else r = {1'b0, s};
        return r;
    endfunction

    function automatic logic [WIDE_W:0] clamp32(logic [WIDE_W-1:0] v);
        logic [WIDE_W:0] r;
        if (!v[WIDE_W-1] && (v[WIDE_W-2:DATA_W-1] != '0))
            r = {1'b1, {(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
        else if (v[WIDE_W-1] && (v[WIDE_W-2:DATA_W-1] != '1))
            r = {1'b1, {(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
        else r = {1'b0, v};
        return r;
    endfunction

    // Knot tables.
    logic [31:0]       idx32;
    logic              tbl_we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] abs_rd, ord_rd, cur_rd;

    assign idx32  = {22'b0, knot_index};
    assign tbl_we = cmd.wr_en && (idx32 < 32'(MAX_POINTS));
    assign waddr  = idx32[IDX_W-1:0];

    csed_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_abs (
        .aclk(aclk), .we(tbl_we), .waddr(waddr), .wdata(knot_abscissa),
        .raddr(rd_addr), .rdata(abs_rd)
    );
    csed_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_ord (
        .aclk(aclk), .we(tbl_we), .waddr(waddr), .wdata(knot_ordinate),
        .raddr(rd_addr), .rdata(ord_rd)
    );
    csed_ram #(.WIDTH(DATA_W), .DEPTH(MAX_POINTS)) u_cur (
        .aclk(aclk), .we(tbl_we), .waddr(waddr), .wdata(knot_curvature),
        .raddr(rd_addr), .rdata(cur_rd)
    );

    // Working registers, 64-bit signed with FRAC_BITS fraction bits.
    logic [WIDE_W-1:0] x_reg, xlo_reg, xhi_reg, ylo_reg, yhi_reg, clo_reg, chi_reg;
    logic [WIDE_W-1:0] h_reg, a_reg, b_reg, t_reg, u_reg, v_reg, w_reg;

    function automatic logic [WIDE_W-1:0] sext(logic [DATA_W-1:0] v);
        return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    logic [WIDE_W-1:0] src_a, src_b;

    always_comb begin
        case (cmd.insn.sa)
            R_X:     src_a = x_reg;
            R_XLO:   src_a = xlo_reg;
            R_XHI:   src_a = xhi_reg;
            R_YLO:   src_a = ylo_reg;
            R_YHI:   src_a = yhi_reg;
            R_CLO:   src_a = clo_reg;
            R_CHI:   src_a = chi_reg;
            R_H:     src_a = h_reg;
            R_A:     src_a = a_reg;
            R_B:     src_a = b_reg;
            R_T:     src_a = t_reg;
            R_U:     src_a = u_reg;
            R_V:     src_a = v_reg;
            R_W:     src_a = w_reg;
            R_ONE:   src_a = ONE_Q;
            default: src_a = '0;
        endcase
        case (cmd.insn.sb)
            R_X:     src_b = x_reg;
            R_XLO:   src_b = xlo_reg;
            R_XHI:   src_b = xhi_reg;
            R_YLO:   src_b = ylo_reg;
            R_YHI:   src_b = yhi_reg;
            R_CLO:   src_b = clo_reg;
            R_CHI:   src_b = chi_reg;
            R_H:     src_b = h_reg;
            R_A:     src_b = a_reg;
            R_B:     src_b = b_reg;
            R_T:     src_b = t_reg;
            R_U:     src_b = u_reg;
            R_V:     src_b = v_reg;
            R_W:     src_b = w_reg;
            R_ONE:   src_b = ONE_Q;
            default: src_b = '0;
        endcase
    end

    // Operation unit state.
    alu_op_t           op_reg;
    reg_sel_t          dst_reg;
    logic              busy_reg, done_reg, sat_reg;
    logic [7:0]        cnt_reg;
    logic [WIDE_W-1:0] opa_reg, opb_reg, dm_reg, rem_reg;
    logic              neg_reg;
    logic [127:0]      acc_reg, dvd_reg;

    logic [WIDE_W-1:0] ma, mb;
    logic [127:0]      div_init;
    logic [31:0]       pp_x, pp_y;
    logic [63:0]       pp;
    logic [127:0]      pp_sh, rnd;
    logic [WIDE_W:0]   rem_sh;
    logic              ge;
    logic [WIDE_W:0]   res;

    assign ma = mag(src_a);
    assign mb = mag(src_b);
    assign div_init = ({64'b0, ma} << FRAC_BITS) + {65'b0, mb[WIDE_W-1:1]};

    always_comb begin
        pp_x  = cnt_reg[1] ? opa_reg[63:32] : opa_reg[31:0];
        pp_y  = cnt_reg[0] ? opb_reg[63:32] : opb_reg[31:0];
        pp    = 64'(pp_x) * 64'(pp_y);
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {64'b0, pp};
            2'd3:    pp_sh = {pp, 64'b0};
            default: pp_sh = {32'b0, pp, 32'b0};
        endcase
        rnd    = acc_reg + (128'(1) << (FRAC_BITS - 1));
        rem_sh = {rem_reg, dvd_reg[127]};
        ge     = rem_sh >= {1'b0, dm_reg};
        case (op_reg)
            OP_ADD:   res = sat_add(opa_reg, opb_reg);
            OP_SUB:   res = sat_sub(opa_reg, opb_reg);
            OP_CLAMP: res = clamp32(opa_reg);
            OP_MUL:   res = from_mag(rnd[FRAC_BITS +: WIDE_W], neg_reg,
                                     (rnd >> (FRAC_BITS + WIDE_W)) != '0);
            OP_DIV6:  res = from_mag({1'b0, acc_reg[127:WIDE_W+1]}, neg_reg, 1'b0);
            default:  res = from_mag(dvd_reg[WIDE_W-1:0], neg_reg, dvd_reg[127:64] != '0);
        endcase
    end

    logic finish;
    always_comb begin
        case (op_reg)
            OP_MUL, OP_DIV6:    finish = busy_reg && (cnt_reg == 8'd4);
            OP_DIV:             finish = busy_reg && (cnt_reg == 8'd128);
            default:            finish = busy_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end else begin
            done_reg <= finish && !cmd.start;
            if (cmd.clear_sat) begin
                sat_reg <= 1'b0;
            end
            if (cmd.start) begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.insn.op;
                dst_reg  <= cmd.insn.dst;
                cnt_reg  <= '0;
                acc_reg  <= '0;
                rem_reg  <= '0;
                case (cmd.insn.op)
                    OP_MUL: begin
                        opa_reg <= ma;
                        opb_reg <= mb;
                        neg_reg <= src_a[WIDE_W-1] ^ src_b[WIDE_W-1];
                    end
                    OP_DIV: begin
                        dvd_reg <= div_init;
                        dm_reg  <= mb;
                        neg_reg <= src_a[WIDE_W-1] ^ src_b[WIDE_W-1];
                    end
                    OP_DIV6: begin
                        opa_reg <= (ma + WIDE_W'(3)) >> 1;
                        opb_reg <= DIV3_MAGIC;
                        neg_reg <= src_a[WIDE_W-1];
                    end
                    default: begin
                        opa_reg <= src_a;
                        opb_reg <= src_b;
                    end
                endcase
            end else if (finish) begin
                busy_reg <= 1'b0;
                if (res[WIDE_W]) begin
                    sat_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 8'd1;
                if (op_reg inside {OP_MUL, OP_DIV6}) begin
                    acc_reg <= acc_reg + pp_sh;
                end else begin
                    rem_reg <= ge ? WIDE_W'(rem_sh - {1'b0, dm_reg}) : rem_sh[WIDE_W-1:0];
                    dvd_reg <= {dvd_reg[126:0], ge};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_x) begin
            x_reg <= sext(query_x);
        end
        if (cmd.load_lo) begin
            xlo_reg <= sext(abs_rd);
            ylo_reg <= sext(ord_rd);
            clo_reg <= sext(cur_rd);
        end
        if (cmd.load_hi) begin
            xhi_reg <= sext(abs_rd);
            yhi_reg <= sext(ord_rd);
            chi_reg <= sext(cur_rd);
        end
        if (finish) begin
            case (dst_reg)
                R_H:     h_reg <= res[WIDE_W-1:0];
                R_A:     a_reg <= res[WIDE_W-1:0];
                R_B:     b_reg <= res[WIDE_W-1:0];
                R_T:     t_reg <= res[WIDE_W-1:0];
                R_U:     u_reg <= res[WIDE_W-1:0];
                R_V:     v_reg <= res[WIDE_W-1:0];
                R_W:     w_reg <= res[WIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Result register.
    logic [DATA_W-1:0] val_reg, d1_reg, d2_reg;
    logic              bad_reg, osat_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (cmd.bad) begin
                val_reg  <= '0;
                d1_reg   <= '0;
                d2_reg   <= '0;
                bad_reg  <= 1'b1;
                osat_reg <= 1'b0;
            end else begin
                val_reg  <= v_reg[DATA_W-1:0];
                d1_reg   <= w_reg[DATA_W-1:0];
                d2_reg   <= t_reg[DATA_W-1:0];
                bad_reg  <= 1'b0;
                osat_reg <= sat_reg;
            end
        end
    end

    assign interp_value  = val_reg;
    assign first_deriv   = d1_reg;
    assign second_deriv  = d2_reg;
    assign bad_spacing   = bad_reg;
    assign saturated     = osat_reg;

    assign status.done   = done_reg;
    assign status.h_zero = (h_reg == '0);
    assign status.gt     = $signed(abs_rd) > $signed(x_reg[DATA_W-1:0]);

endmodule

>>> hdl/csed_ctrl.sv
// Controller: bisection search, knot fetch, program sequencing and output handshake.
// Depends on csed_pkg.
module csed_ctrl
    import csed_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [10:0]                   cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic                          s_action,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output cmd_t                          cmd,
    output logic [$clog2(MAX_POINTS)-1:0] rd_addr,
    input  status_t                       status
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    state_t           state_reg, state_next;
    logic [10:0]      pcount_reg;
    logic [IDX_W-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [PC_W-1:0]  pc_reg, pc_next;
    logic             bad_reg, bad_next;
    logic             mvalid_reg, mvalid_next;

    logic [31:0]      n32;
    logic [31:0]      n_m1;
    logic [IDX_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] span;
    logic             accept;

    always_comb begin
        n32 = {21'b0, pcount_reg};
        if (n32 < 32'd2) n32 = 32'd2;
        if (n32 > 32'(MAX_POINTS)) n32 = 32'(MAX_POINTS);
        n_m1 = n32 - 32'd1;
    end

    assign mid_sum = {1'b0, hi_reg} + {1'b0, lo_reg};
    assign mid     = mid_sum[IDX_W:1];
    assign span    = hi_reg - lo_reg;
    assign accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pcount_reg <= 11'd2;
            mvalid_reg <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            pc_reg     <= '0;
            bad_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
            lo_reg     <= lo_next;
            hi_reg     <= hi_next;
            pc_reg     <= pc_next;
            bad_reg    <= bad_next;
            if (cfg_we) begin
                pcount_reg <= cfg_wdata;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pc_next    = pc_reg;
        bad_next   = bad_reg;
        cmd        = '0;
        cmd.insn   = prog(pc_reg);
        cmd.bad    = bad_reg;
        rd_addr    = mid;
        s_tready   = (state_reg == ST_IDLE);
        mvalid_next = mvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_action) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.load_x    = 1'b1;
                        cmd.clear_sat = 1'b1;
                        lo_next       = '0;
                        hi_next       = n_m1[IDX_W-1:0];
                        state_next    = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (span > IDX_W'(1)) begin
                    state_next = ST_CMP;
                end else begin
                    state_next = ST_LOAD_LO;
                end
            end
            ST_CMP: begin
                // Table data for the midpoint arrived this cycle.
                if (status.gt) hi_next = mid;
                else lo_next = mid;
                state_next = ST_SEARCH;
            end
            ST_LOAD_LO: begin
                rd_addr    = lo_reg;
                state_next = ST_LOAD_HI;
            end
            ST_LOAD_HI: begin
                rd_addr     = hi_reg;
                cmd.load_lo = 1'b1;
                state_next  = ST_LOAD_END;
            end
            ST_LOAD_END: begin
                cmd.load_hi = 1'b1;
                pc_next     = '0;
                state_next  = ST_ISSUE;
            end
            ST_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (status.done) begin
                    if (pc_reg == '0 && status.h_zero) begin
                        bad_next   = 1'b1;
                        state_next = ST_FINISH;
                    end else if (pc_reg == PROG_LAST) begin
                        bad_next   = 1'b0;
                        state_next = ST_FINISH;
                    end else begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_FINISH: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = mvalid_reg;

endmodule

>>> hdl/cubic_spline_eval_deriv_top.sv
// Knot write: written into the tables as it is accepted. Query: a bisection search over the
// knots, a fetch of the two bracketing knots, then the program of adds, subtracts, clamps,
// multiplies, divides by six and three fixed-point divides on the shared bit-serial divider.
// One item is in work at a time; a finished result waits in the output register meanwhile.
// Reset (aresetn low, synchronous) returns the controller to idle, drops m_tvalid and sets
// point_count to 2; the knot tables keep contents, undefined until written.
module cubic_spline_eval_deriv_top
    import csed_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: point_count, the number of knots the search covers.
    input  logic         cfg_we,
    input  logic [10:0]  cfg_wdata,
    // Request channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, from bit 0: knot_index[9:0], knot_abscissa[41:10], knot_ordinate[73:42],
    // knot_curvature[105:74], query_x[137:106], zero fill to 144 bits.
    input  logic [143:0] s_tdata,
    // tuser: action (0 writes a knot, 1 evaluates at query_x).
    input  logic [0:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, from bit 0: interp_value[31:0], first_deriv[63:32], second_deriv[95:64].
    output logic [95:0]  m_tdata,
    // tuser, from bit 0: bad_spacing, saturated.
    output logic [1:0]   m_tuser
);

    localparam int IDX_W = $clog2(MAX_POINTS);

    cmd_t              cmd;
    status_t           status;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] interp_value, first_deriv, second_deriv;
    logic              bad_spacing, saturated;

    // The controller runs the search and sequences the arithmetic program.
    csed_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_action  (s_tuser[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .status    (status)
    );

    // The datapath holds the tables, working registers and the result register.
    csed_dp #(.MAX_POINTS(MAX_POINTS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .status         (status),
        .knot_index     (s_tdata[9:0]),
        .knot_abscissa  (s_tdata[41:10]),
        .knot_ordinate  (s_tdata[73:42]),
        .knot_curvature (s_tdata[105:74]),
        .query_x        (s_tdata[137:106]),
        .interp_value   (interp_value),
        .first_deriv    (first_deriv),
        .second_deriv   (second_deriv),
        .bad_spacing    (bad_spacing),
        .saturated      (saturated)
    );

    assign m_tdata = {second_deriv, first_deriv, interp_value};
    assign m_tuser = {saturated, bad_spacing};

endmodule

>>> hdl/csed_checker.sv
// Port-level checks for the spline evaluator, bound to the top level.
// Depends only on the top level's ports.
module csed_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_reset_clears_valid: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 96'd0) && !m_tuser[1])
        else $error("bad spacing result not zero");

endmodule

bind cubic_spline_eval_deriv_top csed_checker u_csed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/tb.sv
// Testbench for cubic_spline_eval_deriv_top: knot writes, queries and point_count changes.
// Depends on csed_pkg and the block's RTL; the expected results come from an in-bench predictor.
module tb;
    import csed_pkg::*;

    localparam int      FRAC      = 16;
    localparam int      TAB_DEPTH = 1024;
    localparam int      WD_LIMIT  = 20000;
    localparam int      ITEM_GOAL = 1150;
    localparam bit      ACT_WRITE = 1'b0;
    localparam bit      ACT_QUERY = 1'b1;
    localparam longint  QMAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint  QMIN      = 64'sh8000_0000_0000_0000;
    localparam longint  ONE_Q     = 64'sd1 << FRAC;

    typedef struct {
        logic [31:0] value;
        logic [31:0] slope;
        logic [31:0] curve;
        logic        bad;
        logic        clip;
    } spline_result_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [10:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    cubic_spline_eval_deriv_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the knot tables, the point count and which entries hold data.
    longint         knot_x [TAB_DEPTH];
    longint         knot_y [TAB_DEPTH];
    longint         knot_c [TAB_DEPTH];
    bit             knot_written [TAB_DEPTH];
    int unsigned    point_count;
    bit             sat_seen;

    spline_result_t pending_results[$];
    int             errors;
    int             items_sent;
    bit             calm;
    int             hold_len;
    longint         set_lo;
    longint         set_hi;
    int             set_size;

    // ---------------------------------------------------------------------
    // Saturating Q16.16 arithmetic on 64-bit intermediates.
    // ---------------------------------------------------------------------
    function automatic logic [63:0] mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint from_mag(logic [63:0] m, bit neg, bit over);
        if (neg) begin
            if (over || m > 64'h8000_0000_0000_0000) begin
                sat_seen = 1'b1;
                return QMIN;
            end
            return -longint'(m);
        end
        if (over || m[63]) begin
            sat_seen = 1'b1;
            return QMAX;
        end
        return longint'(m);
    endfunction

    function automatic longint sat_add(longint a, longint b);
        logic signed [64:0] s;
        s = a;
        s = s + b;
        if (s > QMAX) begin
            sat_seen = 1'b1;
            return QMAX;
        end
        if (s < QMIN) begin
            sat_seen = 1'b1;
            return QMIN;
        end
        return longint'(s);
    endfunction

    function automatic longint sat_sub(longint a, longint b);
        logic signed [64:0] s;
        s = a;
        s = s - b;
        if (s > QMAX) begin
            sat_seen = 1'b1;
            return QMAX;
        end
        if (s < QMIN) begin
            sat_seen = 1'b1;
            return QMIN;
        end
        return longint'(s);
    endfunction

    // Exact product, then right shift by FRAC with round half away from zero.
    function automatic longint fx_mul(longint p, longint q);
        logic [127:0] prod;
        prod = {64'b0, mag(p)} * {64'b0, mag(q)};
        prod = prod + (128'd1 << (FRAC - 1));
        return from_mag(prod[FRAC+63:FRAC], (p < 0) != (q < 0), |prod[127:FRAC+64]);
    endfunction

    function automatic longint fx_div(longint n, longint d);
        logic [127:0] num;
        logic [127:0] quo;
        logic [63:0]  dm;
        dm  = mag(d);
        num = ({64'b0, mag(n)} << FRAC) + {64'b0, dm >> 1};
        quo = num / {64'b0, dm};
        return from_mag(quo[63:0], (n < 0) != (d < 0), |quo[127:64]);
    endfunction

    function automatic longint div_by6(longint v);
        return from_mag((mag(v) + 64'd3) / 64'd6, v < 0, 1'b0);
    endfunction

    function automatic longint triple(longint v);
        return sat_add(sat_add(v, v), v);
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) begin
            sat_seen = 1'b1;
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            sat_seen = 1'b1;
            v = -64'sd2147483648;
        end
        return v[31:0];
    endfunction

    function automatic int unsigned active_count();
        if (point_count < 2) return 2;
        if (point_count > TAB_DEPTH) return TAB_DEPTH;
        return point_count;
    endfunction

    // Expected answer of one query against the shadow tables.
    function automatic spline_result_t eval_spline(logic [31:0] qx_bits);
        spline_result_t r;
        int unsigned lo, hi, k;
        longint x, h, a, b, t, u, val, d1, d2;
        x  = longint'($signed(qx_bits));
        lo = 0;
        hi = active_count() - 1;
        while (hi - lo > 1) begin
            k = (hi + lo) >> 1;
            if (knot_x[k] > x) hi = k;
            else lo = k;
        end
        sat_seen = 1'b0;
        h = sat_sub(knot_x[hi], knot_x[lo]);
        if (h == 0) begin
            r = '{32'd0, 32'd0, 32'd0, 1'b1, 1'b0};
            return r;
        end
        a = fx_div(sat_sub(knot_x[hi], x), h);
        b = fx_div(sat_sub(x, knot_x[lo]), h);

        t   = fx_mul(sat_sub(fx_mul(fx_mul(a, a), a), a), knot_c[lo]);
        u   = fx_mul(sat_sub(fx_mul(fx_mul(b, b), b), b), knot_c[hi]);
        val = sat_add(sat_add(fx_mul(a, knot_y[lo]), fx_mul(b, knot_y[hi])),
                      div_by6(fx_mul(sat_add(t, u), fx_mul(h, h))));

        t  = div_by6(fx_mul(fx_mul(sat_sub(triple(fx_mul(a, a)), ONE_Q), h), knot_c[lo]));
        u  = div_by6(fx_mul(fx_mul(sat_sub(triple(fx_mul(b, b)), ONE_Q), h), knot_c[hi]));
        d1 = sat_add(sat_sub(fx_div(sat_sub(knot_y[hi], knot_y[lo]), h), t), u);

        d2 = sat_add(fx_mul(a, knot_c[lo]), fx_mul(b, knot_c[hi]));

        r.value = clip32(val);
        r.slope = clip32(d1);
        r.curve = clip32(d2);
        r.bad   = 1'b0;
        r.clip  = sat_seen;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Request driver. The shadow state is updated when the request is taken.
    // ---------------------------------------------------------------------
    task automatic send_item(bit act, logic [9:0] idx, logic [31:0] kx, logic [31:0] ky,
                             logic [31:0] kc, logic [31:0] qx);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, qx, kc, ky, kx, idx};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (act == ACT_WRITE) begin
            knot_x[idx]       = longint'($signed(kx));
            knot_y[idx]       = longint'($signed(ky));
            knot_c[idx]       = longint'($signed(kc));
            knot_written[idx] = 1'b1;
        end else begin
            pending_results.push_back(eval_spline(qx));
        end
    endtask

    task automatic write_knot(logic [9:0] idx, logic [31:0] kx, logic [31:0] ky,
                              logic [31:0] kc);
        send_item(ACT_WRITE, idx, kx, ky, kc, $urandom);
    endtask

    // Queries only touch written entries: any entry the bisection would read that
    // holds no data yet is first filled with an ascending abscissa.
    task automatic query_at(logic [31:0] qx);
        int unsigned lo, hi, k;
        longint x;
        x  = longint'($signed(qx));
        lo = 0;
        hi = active_count() - 1;
        while (hi - lo > 1) begin
            k = (hi + lo) >> 1;
            fill_if_empty(k);
            if (knot_x[k] > x) hi = k;
            else lo = k;
        end
        fill_if_empty(lo);
        fill_if_empty(hi);
        send_item(ACT_QUERY, 10'($urandom), $urandom, $urandom, $urandom, qx);
    endtask

    task automatic fill_if_empty(int unsigned idx);
        longint ax;
        if (!knot_written[idx]) begin
            ax = -(64'sd1 << 30) + longint'(idx) * (64'sd1 << 21);
            write_knot(10'(idx), ax[31:0], rnd_value(), rnd_value());
        end
    endtask

    // Waits until the block holds no work, then a short margin for a write in flight.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_count(logic [10:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        point_count = v;
    endtask

    function automatic logic [31:0] rnd_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0:       v = $urandom;
            1:       v = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            2:       v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            3:       v = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: case ($urandom_range(0, 3))
                0:       v = 32'h8000_0000;
                1:       v = 32'h7FFF_FFFF;
                2:       v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        endcase
        return v;
    endfunction

    // Writes k knots with non-decreasing abscissas at indices 0..k-1.
    task automatic build_set(int k);
        longint ax;
        longint step;
        ax = longint'($signed($urandom_range(0, 32'h4000_0000))) - (64'sd1 << 30);
        if ($urandom_range(0, 3) == 0) ax = -64'sd2147483648 + $urandom_range(0, 255);
        set_lo   = ax;
        set_size = k;
        for (int i = 0; i < k; i++) begin
            write_knot(i[9:0], ax[31:0], rnd_value(), rnd_value());
            set_hi = ax;
            case ($urandom_range(0, 3))
                0:       step = $urandom_range(1, 256);
                1:       step = $urandom_range(32'h0000_1000, 32'h0004_0000);
                2:       step = $urandom_range(32'h0001_0000, 32'h0200_0000);
                default: step = $urandom_range(32'h0100_0000, 32'h1000_0000);
            endcase
            ax = ax + step;
            if (ax > 64'sd2147483647) ax = 64'sd2147483647;
        end
    endtask

    function automatic logic [31:0] pick_x();
        longint span, x;
        span = set_hi - set_lo;
        case ($urandom_range(0, 7))
            6:       x = knot_x[$urandom_range(0, set_size - 1)];
            7:       x = longint'($signed($urandom));
            default: begin
                x = set_lo - span / 8
                    + longint'({$urandom, $urandom} >> 1) % (span + span / 4 + 1);
            end
        endcase
        if (x > 64'sd2147483647) x = 64'sd2147483647;
        if (x < -64'sd2147483648) x = -64'sd2147483648;
        return x[31:0];
    endfunction

    // ---------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request.
    // ---------------------------------------------------------------------
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compares each accepted result with the oldest expectation, field by field.
    always @(posedge aclk) begin
        spline_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected: tdata=%h tuser=%b",
                         $realtime, m_tdata, m_tuser);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.value) begin
                    $display("%0t: interp_value expected %h actual %h",
                             $realtime, want.value, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== want.slope) begin
                    $display("%0t: first_deriv expected %h actual %h",
                             $realtime, want.slope, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== want.curve) begin
                    $display("%0t: second_deriv expected %h actual %h",
                             $realtime, want.curve, m_tdata[95:64]);
                    errors++;
                end
                if (m_tuser[0] !== want.bad) begin
                    $display("%0t: bad_spacing expected %b actual %b",
                             $realtime, want.bad, m_tuser[0]);
                    errors++;
                end
                if (m_tuser[1] !== want.clip) begin
                    $display("%0t: saturated expected %b actual %b",
                             $realtime, want.clip, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither side moves a request for too long.
    int idle_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WD_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Tests.
    // ---------------------------------------------------------------------

    // Two knots on a straight line: interior point and extrapolation both ways.
    task automatic test_linear_pair();
        write_knot(10'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        write_knot(10'd1, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
        query_at(32'h0000_8000);
        query_at(32'h0003_0000);
        query_at(32'hFFFE_0000);
        query_at(32'h0001_0000);
    endtask

    // Field extremes: full-scale knots drive results and intermediates into clipping.
    task automatic test_extremes();
        write_knot(10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        write_knot(10'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        query_at(32'h8000_0000);
        query_at(32'h7FFF_FFFF);
        query_at(32'hFFFF_FFFF);
        write_knot(10'd1, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        query_at(32'h0000_0000);
        write_knot(10'h3FF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    endtask

    // Two knots with one abscissa: the bad-spacing flag with zero results.
    task automatic test_bad_spacing();
        write_knot(10'd0, 32'h0002_0000, 32'h1234_5678, 32'h0000_1000);
        write_knot(10'd1, 32'h0002_0000, 32'h8765_4321, 32'hFFFF_0000);
        query_at(32'h0002_0000);
        query_at(32'h8000_0000);
    endtask

    // Counts below 2 act as 2, counts above the table act as the full table.
    task automatic test_count_limits();
        build_set(4);
        set_count(11'd0);
        query_at(pick_x());
        set_count(11'd1);
        query_at(pick_x());
        set_count(11'd1024);
        query_at(32'h1000_0000);
        query_at(32'h8000_0000);
        set_count(11'd2047);
        query_at(32'h7FFF_FFFF);
        set_count(11'd1025);
        query_at(32'h0000_0000);
        set_count(11'd2);
    endtask

    // The receiver holds off for a long stretch while queries keep coming, so the
    // output register fills and the block stops taking requests.
    task automatic test_backpressure();
        build_set(6);
        set_count(11'd6);
        hold_len = 4000;
        repeat (6) query_at(pick_x());
    endtask

    // Random phases: a fresh non-decreasing set, a count, some noise and many queries.
    task automatic test_random();
        int k;
        logic [10:0] cnt;
        while (items_sent < ITEM_GOAL) begin
            if (items_sent > ITEM_GOAL - 150) calm = 1'b1;
            k = $urandom_range(2, 12);
            build_set(k);
            case ($urandom_range(0, 11))
                0:       cnt = 11'($urandom_range(0, 1));
                1:       cnt = 11'($urandom_range(13, 2047));
                2:       cnt = 11'd1024;
                default: cnt = 11'(k);
            endcase
            set_count(cnt);
            repeat ($urandom_range(3, 10)) begin
                if ($urandom_range(0, 15) == 0) begin
                    write_knot(10'($urandom_range(0, k - 1)), rnd_value(), rnd_value(),
                               rnd_value());
                end
                query_at(pick_x());
            end
        end
    endtask

    initial begin
        aclk        = 1'b0;
        aresetn    <= 1'b0;
        cfg_we     <= 1'b0;
        cfg_wdata  <= 11'd0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= '0;
        errors      = 0;
        items_sent  = 0;
        calm        = 1'b0;
        hold_len    = 0;
        point_count = 2;
        set_lo      = 0;
        set_hi      = 0;
        set_size    = 2;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            knot_x[i]       = 0;
            knot_y[i]       = 0;
            knot_c[i]       = 0;
            knot_written[i] = 1'b0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_linear_pair();
        test_extremes();
        test_bad_spacing();
        test_count_limits();
        test_backpressure();
        test_random();

        settle();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/csed_pkg.sv
hdl/csed_ram.sv
hdl/csed_dp.sv
hdl/csed_ctrl.sv
hdl/cubic_spline_eval_deriv_top.sv
hdl/csed_checker.sv
sim/tb.sv
